// File: hdl/keyword_lexer_core_macros.svh
// Assertion macros shared by the keyword lexer RTL.
`ifndef KEYWORD_LEXER_CORE_MACROS_SVH
`define KEYWORD_LEXER_CORE_MACROS_SVH
`ifndef SYNTH
// Property checked every clock, masked while reset is high.
`define KLC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies the outcome in the next.
`define KLC_ASSERT_NEXT(label, clk, rst, cond, outcome, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (outcome)) \
      else $error(msg);
`else
`define KLC_ASSERT(label, clk, rst, prop, msg)
`define KLC_ASSERT_NEXT(label, clk, rst, cond, outcome, msg)
`endif
`endif

// File: hdl/kwl_pkg.sv
// Types, constants and helper functions of the keyword lexer.
`timescale 1ns / 1ps
package kwl_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int FIELD_W      = 16;
   localparam int KIND_W       = 5;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_FIELDS_W = 3 * FIELD_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;
   localparam int BUNDLE_SLOTS = 3;
   localparam int KW_COUNT     = 7;
   localparam int KW_SLOTS     = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_LET     = 5'd0,
      KIND_FN      = 5'd1,
      KIND_YAP     = 5'd2,
      KIND_RETURN  = 5'd3,
      KIND_IF      = 5'd4,
      KIND_ELSE    = 5'd5,
      KIND_WHILE   = 5'd6,
      KIND_IDENT   = 5'd7,
      KIND_INT     = 5'd8,
      KIND_PLUS    = 5'd9,
      KIND_MINUS   = 5'd10,
      KIND_STAR    = 5'd11,
      KIND_SLASH   = 5'd12,
      KIND_ASSIGN  = 5'd13,
      KIND_EQ      = 5'd14,
      KIND_BANG    = 5'd15,
      KIND_NE      = 5'd16,
      KIND_LT      = 5'd17,
      KIND_LE      = 5'd18,
      KIND_GT      = 5'd19,
      KIND_GE      = 5'd20,
      KIND_SEMI    = 5'd21,
      KIND_COMMA   = 5'd22,
      KIND_LPAREN  = 5'd23,
      KIND_RPAREN  = 5'd24,
      KIND_LBRACE  = 5'd25,
      KIND_RBRACE  = 5'd26,
      KIND_UNKNOWN = 5'd27,
      KIND_EOF     = 5'd28
   } kind_type;

   // scanner state, one-hot
   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_IDENT   = 5'b00010,
      MODE_INT     = 5'b00100,
      MODE_COMMENT = 5'b01000,
      MODE_OPER    = 5'b10000
   } mode_type;

   // first char of a possible two-char operator
   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_ASSIGN  = 3'd1,
      OP_BANG    = 3'd2,
      OP_LESS    = 3'd3,
      OP_GREATER = 3'd4,
      OP_SLASH   = 3'd5
   } oper_type;

   typedef struct packed {
      kind_type               kind;
      logic [FIELD_W-1:0]     start;
      logic [FIELD_W-1:0]     length;
      logic [FIELD_W-1:0]     line;
      logic                   error_seen;
   } token_type;

   // all tokens caused by one source byte, in order
   typedef struct packed {
      logic [1:0]                      count;
      token_type [BUNDLE_SLOTS-1:0]    slot;
   } bundle_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ONES  = 8'hFF;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
      '{"l", "e", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"f", "n", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"y", "a", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"r", "e", "t", "u", "r", "n", CH_NUL, CH_NUL},
      '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"e", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"w", "h", "i", "l", "e", CH_NUL, CH_NUL, CH_NUL}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd2, 3'd3, 3'd6, 3'd2, 3'd4, 3'd5};

   function automatic logic is_alpha(logic [7:0] b);
      return b inside {["a":"z"], ["A":"Z"], "_"};
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b inside {["0":"9"]};
   endfunction

   // drop every keyword whose char at this index differs from b
   function automatic logic [KW_COUNT-1:0] kw_mask_step(logic [KW_COUNT-1:0] mask,
                                                        logic [2:0] idx, logic short_run,
                                                        logic [7:0] b);
      logic [KW_COUNT-1:0] nxt;
      nxt = mask;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!(short_run && (idx < KW_LEN[k]) && (KW_TEXT[k][idx] == b))) begin
            nxt[k] = 1'b0;
         end
      end
      return nxt;
   endfunction

   function automatic kind_type kw_kind(logic [KW_COUNT-1:0] mask, logic [2:0] len,
                                        logic short_run);
      kind_type kind;
      kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (mask[k] && short_run && (len == KW_LEN[k])) begin
            kind = kind_type'(KIND_W'(k));
         end
      end
      return kind;
   endfunction

   function automatic kind_type single_op_kind(oper_type op);
      kind_type kind;
      case (op)
         OP_ASSIGN:  kind = KIND_ASSIGN;
         OP_BANG:    kind = KIND_BANG;
         OP_LESS:    kind = KIND_LT;
         OP_GREATER: kind = KIND_GT;
         default:    kind = KIND_SLASH;
      endcase
      return kind;
   endfunction

   function automatic kind_type pair_op_kind(oper_type op);
      kind_type kind;
      case (op)
         OP_ASSIGN:  kind = KIND_EQ;
         OP_BANG:    kind = KIND_NE;
         OP_LESS:    kind = KIND_LE;
         default:    kind = KIND_GE;
      endcase
      return kind;
   endfunction

endpackage

// File: hdl/kwl_scanner.sv
// Input register, scanner state and per-byte token generation.
`timescale 1ns / 1ps
`include "keyword_lexer_core_macros.svh"
module kwl_scanner #(
   parameter int POSITION_BITS = kwl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kwl_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   output logic                              bundle_valid,
   input  logic                              bundle_ready,
   output kwl_pkg::bundle_type               bundle
);
   import kwl_pkg::*;

   typedef logic [POSITION_BITS-1:0] pos_type;

   function automatic pos_type sat_inc(pos_type v);
      return (v == '1) ? v : v + pos_type'(1);
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(pos_type v);
      logic [FIELD_W+POSITION_BITS-1:0] wide;
      wide = {{FIELD_W{1'b0}}, v};
      return wide[FIELD_W-1:0];
   endfunction

   function automatic logic has_pending(mode_type m);
      return (m == MODE_IDENT) || (m == MODE_INT) || (m == MODE_OPER);
   endfunction

   function automatic token_type flush_tok(mode_type m, oper_type op,
                                           logic [KW_COUNT-1:0] mask, pos_type run,
                                           pos_type bgn, pos_type ln);
      token_type t;
      t.start      = to_field(bgn);
      t.length     = to_field(run);
      t.line       = to_field(ln);
      t.error_seen = 1'b0;
      case (m)
         MODE_IDENT: t.kind = kw_kind(mask, run[2:0], ~|run[POSITION_BITS-1:3]);
         MODE_INT:   t.kind = KIND_INT;
         MODE_OPER: begin
            t.kind   = single_op_kind(op);
            t.length = FIELD_W'(1);
         end
         default:    t.kind = KIND_UNKNOWN;
      endcase
      return t;
   endfunction

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;

   mode_type             mode_ff, mode_in;
   oper_type             oper_ff, oper_in;
   logic [KW_COUNT-1:0]  mask_ff, mask_in;
   pos_type              begin_ff, begin_in;
   pos_type              run_ff, run_in;
   pos_type              pos_ff, pos_in;
   pos_type              line_ff, line_in;
   logic                 unk_ff, unk_in;

   logic                 advance;
   logic                 a_valid, s_valid, c_valid;
   token_type            a_tok, s_tok, c_tok;

   assign advance      = in_valid_ff & bundle_ready;
   assign req_tready   = ~in_valid_ff | bundle_ready;
   assign bundle_valid = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[7:0];
         in_last_ff <= req_tlast;
      end
   end

   // a_* : token closed by the old state, s_* : token begun or closed by this
   // byte, c_* : end of source
   always_comb begin
      logic     term;
      logic     fresh;
      logic     clear;
      kind_type s_kind;

      term   = (in_byte_ff == CH_NUL) || (in_byte_ff == CH_ONES);
      fresh  = 1'b1;
      clear  = 1'b0;
      s_kind = KIND_UNKNOWN;

      mode_in  = mode_ff;
      oper_in  = oper_ff;
      mask_in  = mask_ff;
      begin_in = begin_ff;
      run_in   = run_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      unk_in   = unk_ff;

      a_valid = 1'b0;
      s_valid = 1'b0;
      c_valid = 1'b0;
      a_tok   = flush_tok(mode_ff, oper_ff, mask_ff, run_ff, begin_ff, line_ff);
      s_tok   = a_tok;
      c_tok   = '{kind: KIND_EOF, start: to_field(pos_ff), length: '0,
                  line: to_field(line_ff), error_seen: unk_ff};

      if (term) begin
         a_valid = has_pending(mode_ff);
         c_valid = 1'b1;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha(in_byte_ff) || is_digit(in_byte_ff)) begin
                  mask_in = kw_mask_step(mask_ff, run_ff[2:0], ~|run_ff[POSITION_BITS-1:3],
                                         in_byte_ff);
                  run_in  = sat_inc(run_ff);
                  fresh   = 1'b0;
               end else begin
                  a_valid = 1'b1;
                  clear   = 1'b1;
               end
            end
            MODE_INT: begin
               if (is_digit(in_byte_ff)) begin
                  run_in = sat_inc(run_ff);
                  fresh  = 1'b0;
               end else begin
                  a_valid = 1'b1;
                  clear   = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (in_byte_ff == CH_LF) begin
                  mode_in = MODE_IDLE;
               end else begin
                  fresh = 1'b0;
               end
            end
            MODE_OPER: begin
               if ((oper_ff == OP_SLASH) && (in_byte_ff == "/")) begin
                  mode_in = MODE_COMMENT;
                  oper_in = OP_NONE;
                  fresh   = 1'b0;
               end else if ((oper_ff inside {OP_ASSIGN, OP_BANG, OP_LESS, OP_GREATER}) &&
                            (in_byte_ff == "=")) begin
                  a_valid      = 1'b1;
                  a_tok.kind   = pair_op_kind(oper_ff);
                  a_tok.length = FIELD_W'(2);
                  mode_in      = MODE_IDLE;
                  oper_in      = OP_NONE;
                  fresh        = 1'b0;
               end else begin
                  a_valid = 1'b1;
                  clear   = 1'b1;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase

         if (clear) begin
            mode_in = MODE_IDLE;
            oper_in = OP_NONE;
            mask_in = '1;
            run_in  = '0;
         end

         if (fresh) begin
            case (in_byte_ff)
               CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: ;
               CH_LF: line_in = sat_inc(line_ff);
               "+": begin s_valid = 1'b1; s_kind = KIND_PLUS;   end
               "-": begin s_valid = 1'b1; s_kind = KIND_MINUS;  end
               "*": begin s_valid = 1'b1; s_kind = KIND_STAR;   end
               ";": begin s_valid = 1'b1; s_kind = KIND_SEMI;   end
               ",": begin s_valid = 1'b1; s_kind = KIND_COMMA;  end
               "(": begin s_valid = 1'b1; s_kind = KIND_LPAREN; end
               ")": begin s_valid = 1'b1; s_kind = KIND_RPAREN; end
               "{": begin s_valid = 1'b1; s_kind = KIND_LBRACE; end
               "}": begin s_valid = 1'b1; s_kind = KIND_RBRACE; end
               "=": begin oper_in = OP_ASSIGN;  mode_in = MODE_OPER; begin_in = pos_ff; end
               "!": begin oper_in = OP_BANG;    mode_in = MODE_OPER; begin_in = pos_ff; end
               "<": begin oper_in = OP_LESS;    mode_in = MODE_OPER; begin_in = pos_ff; end
               ">": begin oper_in = OP_GREATER; mode_in = MODE_OPER; begin_in = pos_ff; end
               "/": begin oper_in = OP_SLASH;   mode_in = MODE_OPER; begin_in = pos_ff; end
               default: begin
                  if (is_alpha(in_byte_ff)) begin
                     mode_in  = MODE_IDENT;
                     begin_in = pos_ff;
                     mask_in  = kw_mask_step('1, 3'd0, 1'b1, in_byte_ff);
                     run_in   = pos_type'(1);
                  end else if (is_digit(in_byte_ff)) begin
                     mode_in  = MODE_INT;
                     begin_in = pos_ff;
                     run_in   = pos_type'(1);
                  end else begin
                     unk_in  = 1'b1;
                     s_valid = 1'b1;
                     s_kind  = KIND_UNKNOWN;
                  end
               end
            endcase
         end

         s_tok = '{kind: s_kind, start: to_field(pos_ff), length: FIELD_W'(1),
                   line: to_field(line_ff), error_seen: 1'b0};
         pos_in = sat_inc(pos_ff);

         // end flag: close whatever this byte left open, then eof past it
         if (in_last_ff) begin
            if (has_pending(mode_in)) begin
               s_valid = 1'b1;
               s_tok   = flush_tok(mode_in, oper_in, mask_in, run_in, begin_in, line_in);
            end
            c_valid = 1'b1;
            c_tok   = '{kind: KIND_EOF, start: to_field(pos_in), length: '0,
                        line: to_field(line_in), error_seen: unk_in};
         end
      end

      // eof restarts the source at offset 0, line 1
      if (c_valid) begin
         mode_in  = MODE_IDLE;
         oper_in  = OP_NONE;
         mask_in  = '1;
         begin_in = '0;
         run_in   = '0;
         pos_in   = '0;
         line_in  = pos_type'(1);
         unk_in   = 1'b0;
      end
   end

   // pack the live tokens to the low slots
   always_comb begin
      bundle.count   = {1'b0, a_valid} + {1'b0, s_valid} + {1'b0, c_valid};
      bundle.slot[0] = a_valid ? a_tok : (s_valid ? s_tok : c_tok);
      bundle.slot[1] = (a_valid && s_valid) ? s_tok : c_tok;
      bundle.slot[2] = c_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         oper_ff  <= OP_NONE;
         mask_ff  <= '1;
         begin_ff <= '0;
         run_ff   <= '0;
         pos_ff   <= '0;
         line_ff  <= pos_type'(1);
         unk_ff   <= 1'b0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         oper_ff  <= oper_in;
         mask_ff  <= mask_in;
         begin_ff <= begin_in;
         run_ff   <= run_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         unk_ff   <= unk_in;
      end
   end

   `KLC_ASSERT(a_line_nonzero, clock, reset, line_ff != '0, "line counter is zero")
   `KLC_ASSERT(a_full_ends_eof, clock, reset, (in_valid_ff && (bundle.count == 2'd3)) |-> (bundle.slot[2].kind == KIND_EOF), "three tokens without eof last")
   `KLC_ASSERT_NEXT(a_eof_restarts, clock, reset, advance && c_valid, (pos_ff == '0) && (unk_ff == 1'b0) && (mode_ff == MODE_IDLE), "state not restarted after eof")

endmodule

// File: hdl/kwl_token_buf.sv
// Result register holding one byte's tokens and handing them out one per word.
`timescale 1ns / 1ps
`include "keyword_lexer_core_macros.svh"
module kwl_token_buf (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              bundle_valid,
   output logic                              bundle_ready,
   input  kwl_pkg::bundle_type               bundle,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kwl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [kwl_pkg::KIND_W-1:0]        rsp_tuser,
   output logic                              rsp_tlast
);
   import kwl_pkg::*;

   token_type   slot_ff [BUNDLE_SLOTS];
   logic [1:0]  count_ff, count_in;
   logic [1:0]  rd_ff, rd_in;
   logic        load;
   logic        pop;
   logic        last_slot;
   token_type   cur;

   assign rsp_tvalid   = (count_ff != 2'd0);
   assign last_slot    = (rd_ff == (count_ff - 2'd1));
   assign pop          = rsp_tvalid & rsp_tready;
   assign bundle_ready = ~rsp_tvalid | (rsp_tready & last_slot);
   assign load         = bundle_valid & bundle_ready;
   assign cur          = slot_ff[rd_ff];

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, cur.error_seen, cur.line, cur.length, cur.start};
   assign rsp_tuser = cur.kind;
   assign rsp_tlast = last_slot;

   always_comb begin
      count_in = count_ff;
      rd_in    = rd_ff;
      if (load) begin
         count_in = bundle.count;
         rd_in    = 2'd0;
      end else if (pop) begin
         if (last_slot) begin
            count_in = 2'd0;
            rd_in    = 2'd0;
         end else begin
            rd_in = rd_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 2'd0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
      end
      if (load) begin
         for (int i = 0; i < BUNDLE_SLOTS; i++) begin
            slot_ff[i] <= bundle.slot[i];
         end
      end
   end

   `KLC_ASSERT(a_rd_in_range, clock, reset, (count_ff == 2'd0) || (rd_ff < count_ff), "read index beyond held tokens")
   `KLC_ASSERT(a_load_only_when_drained, clock, reset, (bundle_ready && rsp_tvalid) |-> (rsp_tready && rsp_tlast), "bundle taken over undelivered tokens")
   `KLC_ASSERT_NEXT(a_load_shows, clock, reset, load && (bundle.count != 2'd0), rsp_tvalid && (rd_ff == 2'd0), "loaded tokens not presented")

endmodule

// File: hdl/keyword_lexer_core.sv
// Top level of the streaming keyword lexer.
`timescale 1ns / 1ps
// Streaming lexer: one source byte per input word (req_tdata[7:0], req_tlast marks
// the last byte of a source; bytes 0x00 and 0xFF also end it). Each byte yields zero
// to three tokens (closing token, new token, eof), sent as one word each on the rsp
// side; rsp_tlast marks the last token caused by a given byte. Identifiers, integers,
// the seven keywords let fn yap return if else while, operators = == ! != < <= > >=
// + - * / and punctuation ; , ( ) { } are recognized; "//" comments and whitespace
// are dropped, LF counts lines. Any other byte gives an unknown token and sets the
// error flag reported on the eof token. After eof the offset restarts at 0 and the
// line at 1. Offsets, lengths and lines saturate at 2^POSITION_BITS-1 and are shown
// in their low 16 bits. Timing: a byte is registered, scanned combinationally and its
// tokens are loaded into the result register, which presents the first of them; the
// load waits while that register still holds undelivered tokens. The result register
// drains one token per cycle while rsp_tready is high; bytes causing at most one
// token stream at one per clock with rsp_tready high.
module keyword_lexer_core #(
   parameter int POSITION_BITS = kwl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // source bytes
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kwl_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] src_byte
   input  logic                              req_tlast,  // end_of_source
   // tokens
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] token_start, [31:16] token_length, [47:32] token_line, [48] error_seen
   output logic [kwl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [kwl_pkg::KIND_W-1:0]        rsp_tuser,  // [4:0] token_kind
   output logic                              rsp_tlast   // last_of_run
);
   import kwl_pkg::*;

   logic        bundle_valid;
   logic        bundle_ready;
   bundle_type  bundle;

   // byte register, scan state and token formation
   kwl_scanner #(
      .POSITION_BITS (POSITION_BITS)
   ) u_scanner (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .bundle_valid (bundle_valid),
      .bundle_ready (bundle_ready),
      .bundle       (bundle)
   );

   // result register, one token word per cycle while rsp_tready is high
   kwl_token_buf u_token_buf (
      .clock        (clock),
      .reset        (reset),
      .bundle_valid (bundle_valid),
      .bundle_ready (bundle_ready),
      .bundle       (bundle),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
